// ===== design/rplp_pkg.sv =====
`timescale 1ns / 1ps
package rplp_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int IO_BITS = 32;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_LOAD, OP_KPX_N, OP_KPX_D, OP_T1_N, OP_T2_N, OP_C_N, OP_C_D,
    OP_T3_N, OP_T4_N, OP_CX_N, OP_CX_D,
    OP_KK_N, OP_KK_D, OP_D_N,
    OP_KC_N, OP_KC_D,
    OP_Q1_N, OP_Q1_D, OP_Q2_N, OP_Q2_D,
    OP_X_A, OP_X_B, OP_X_N, OP_X_D,
    OP_Y_A, OP_Y_B, OP_Y_N, OP_Y_D,
    OP_VERT, OP_NOP
  } dp_op_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    dp_op_t op;
    logic   gcd_start;   // start Euclid on the selected fraction
    logic   gcd_sel_y;   // 0: x fraction, 1: y fraction
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
  } dp_sts_t;
endpackage

// ===== design/rational_point_line_projection.sv =====
`timescale 1ns / 1ps
// Operation: the request loads on acceptance, then the fraction arithmetic runs
// on one shared multiplier, then two Euclid reductions on a shared radix-2 divider
// (one division per remainder step plus two exact ones). A vertical line skips
// the arithmetic and the reductions and goes from S_CALC straight to S_OUT.
// Throughput: one request at a time; the next is taken once the result leaves.
// Reset: synchronous active-low rst_n clears the controller and flags.
module rational_point_line_projection #(
  parameter int WORD_BITS = rplp_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_point_x_num,
  input  logic [31:0] in_point_x_den,
  input  logic [31:0] in_point_y_num,
  input  logic [31:0] in_point_y_den,
  input  logic [31:0] in_slope_num,
  input  logic [31:0] in_slope_den,
  input  logic [31:0] in_offset_num,
  input  logic [31:0] in_offset_den,
  input  logic        in_is_vertical,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_proj_x_num,
  output logic [31:0] out_proj_x_den,
  output logic [31:0] out_proj_y_num,
  output logic [31:0] out_proj_y_den,
  output logic        out_zero_gcd
);
  rplp_pkg::dp_cmd_t cmd;
  rplp_pkg::dp_sts_t sts;

  rplp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_is_vertical(in_is_vertical), .out_valid(out_valid),
    .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  rplp_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_point_x_num(in_point_x_num), .in_point_x_den(in_point_x_den),
    .in_point_y_num(in_point_y_num), .in_point_y_den(in_point_y_den),
    .in_slope_num(in_slope_num), .in_slope_den(in_slope_den),
    .in_offset_num(in_offset_num), .in_offset_den(in_offset_den),
    .res_x_num(out_proj_x_num), .res_x_den(out_proj_x_den),
    .res_y_num(out_proj_y_num), .res_y_den(out_proj_y_den),
    .res_zero(out_zero_gcd)
  );

  // A request is taken only while no result is pending.
  a_no_take_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request taken while result pending");

  // A result leaves and the block is free on the next cycle.
  a_free_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> (!out_valid && !in_stall))
    else $error("block not free after result");

  // An accepted request makes the block busy.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("not busy after request");
endmodule

// ===== design/rplp_divider.sv =====
`timescale 1ns / 1ps
// Truncating signed divider, one quotient bit per cycle.
module rplp_divider #(
  parameter int WORD_BITS = rplp_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output logic                 done,
  output logic [WORD_BITS-1:0] quotient,
  output logic [WORD_BITS-1:0] remainder
);
  localparam int CW = $clog2(WORD_BITS + 1);

  logic                 busy_r;
  logic [CW-1:0]        cnt_r;
  logic [WORD_BITS-1:0] q_r, b_r;
  logic [WORD_BITS:0]   rem_r;
  logic                 qneg_r, rneg_r;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   shifted;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    shifted = {rem_r[WORD_BITS-1:0], q_r[WORD_BITS-1]};
    trial   = shifted - {1'b0, b_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WORD_BITS);
        q_r    <= dividend[WORD_BITS-1] ? -dividend : dividend;
        b_r    <= divisor[WORD_BITS-1] ? -divisor : divisor;
        rem_r  <= '0;
        qneg_r <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
        rneg_r <= dividend[WORD_BITS-1];
      end else if (busy_r) begin
        if (trial[WORD_BITS]) begin
          rem_r <= shifted;
          q_r   <= {q_r[WORD_BITS-2:0], 1'b0};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[WORD_BITS-2:0], 1'b1};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient  = qneg_r ? -q_r : q_r;
  assign remainder = rneg_r ? -rem_r[WORD_BITS-1:0] : rem_r[WORD_BITS-1:0];
endmodule

// ===== design/rplp_datapath.sv =====
`timescale 1ns / 1ps
// Register file, one shared multiplier, the adds and subtracts, and the GCD/reduction
// sequencer around the shared divider.
module rplp_datapath #(
  parameter int WORD_BITS = rplp_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rplp_pkg::dp_cmd_t    cmd,
  output rplp_pkg::dp_sts_t    sts,
  input  logic [rplp_pkg::IO_BITS-1:0] in_point_x_num,
  input  logic [rplp_pkg::IO_BITS-1:0] in_point_x_den,
  input  logic [rplp_pkg::IO_BITS-1:0] in_point_y_num,
  input  logic [rplp_pkg::IO_BITS-1:0] in_point_y_den,
  input  logic [rplp_pkg::IO_BITS-1:0] in_slope_num,
  input  logic [rplp_pkg::IO_BITS-1:0] in_slope_den,
  input  logic [rplp_pkg::IO_BITS-1:0] in_offset_num,
  input  logic [rplp_pkg::IO_BITS-1:0] in_offset_den,
  output logic [rplp_pkg::IO_BITS-1:0] res_x_num,
  output logic [rplp_pkg::IO_BITS-1:0] res_x_den,
  output logic [rplp_pkg::IO_BITS-1:0] res_y_num,
  output logic [rplp_pkg::IO_BITS-1:0] res_y_den,
  output logic                         res_zero
);
  localparam int W = WORD_BITS;
  localparam int IW = rplp_pkg::IO_BITS;
  typedef logic [W-1:0] word_t;

  typedef enum logic [2:0] {G_IDLE, G_REM, G_DIVN, G_DIVD} gst_t;

  word_t pxn_r, pxd_r, pyn_r, pyd_r, kn_r, kd_r, nn_r, nd_r;
  word_t ta_r, tb_r, cn_r, cd_r, dn_r, dd_r, en_r, ed_r;
  word_t xn_r, xd_r, yn_r, yd_r;
  logic  zero_r;
  word_t prod, pa, pb;
  word_t g_r, h_r, fn_r, fd_r;
  logic  sel_y_r;
  gst_t  gst_r;
  logic  dv_done;
  word_t dv_a, dv_b, dv_q, dv_r;
  logic  go_r;
  logic  dv_go;

  // Wrap input words to the working width.
  function automatic word_t in_w(input logic [IW-1:0] v);
    return word_t'(signed'(v));
  endfunction

  function automatic logic [IW-1:0] out_w(input word_t v);
    return IW'(signed'(v));
  endfunction

  // Operand select for the shared multiplier.
  always_comb begin
    pa = kn_r; pb = pxn_r;
    case (cmd.op)
      rplp_pkg::OP_KPX_N: begin pa = kn_r;  pb = pxn_r; end
      rplp_pkg::OP_KPX_D: begin pa = kd_r;  pb = pxd_r; end
      rplp_pkg::OP_T1_N:  begin pa = ta_r;  pb = pyd_r; end
      rplp_pkg::OP_T2_N:  begin pa = pyn_r; pb = tb_r;  end
      rplp_pkg::OP_C_N:   begin pa = ta_r;  pb = nd_r;  end
      rplp_pkg::OP_C_D:   begin pa = tb_r;  pb = pyd_r; end
      rplp_pkg::OP_T3_N:  begin pa = nn_r;  pb = cd_r;  end
      rplp_pkg::OP_T4_N:  begin pa = cn_r;  pb = nd_r;  end
      rplp_pkg::OP_CX_D:  begin pa = cd_r;  pb = nd_r;  end
      rplp_pkg::OP_KK_N:  begin pa = kn_r;  pb = kn_r;  end
      rplp_pkg::OP_KK_D:  begin pa = kd_r;  pb = kd_r;  end
      rplp_pkg::OP_KC_N:  begin pa = kn_r;  pb = cn_r;  end
      rplp_pkg::OP_KC_D:  begin pa = kd_r;  pb = cd_r;  end
      rplp_pkg::OP_Q1_N:  begin pa = en_r;  pb = dd_r;  end
      rplp_pkg::OP_Q1_D:  begin pa = ed_r;  pb = dn_r;  end
      rplp_pkg::OP_Q2_N:  begin pa = cn_r;  pb = dd_r;  end
      rplp_pkg::OP_Q2_D:  begin pa = cd_r;  pb = dn_r;  end
      rplp_pkg::OP_X_A:   begin pa = pxn_r; pb = ed_r;  end
      rplp_pkg::OP_X_B:   begin pa = en_r;  pb = pxd_r; end
      rplp_pkg::OP_X_D:   begin pa = pxd_r; pb = ed_r;  end
      rplp_pkg::OP_Y_A:   begin pa = pyn_r; pb = cd_r;  end
      rplp_pkg::OP_Y_B:   begin pa = cn_r;  pb = pyd_r; end
      rplp_pkg::OP_Y_D:   begin pa = pyd_r; pb = dd_r;  end
      default: ;
    endcase
  end
  assign prod = pa * pb;

  // Fraction arithmetic, one product per cycle.
  always_ff @(posedge clk) begin
    case (cmd.op)
      rplp_pkg::OP_LOAD: begin
        pxn_r <= in_w(in_point_x_num); pxd_r <= in_w(in_point_x_den);
        pyn_r <= in_w(in_point_y_num); pyd_r <= in_w(in_point_y_den);
        kn_r  <= in_w(in_slope_num);   kd_r  <= in_w(in_slope_den);
        nn_r  <= in_w(in_offset_num);  nd_r  <= in_w(in_offset_den);
      end
      rplp_pkg::OP_KPX_N: ta_r <= prod;
      rplp_pkg::OP_KPX_D: tb_r <= prod;
      rplp_pkg::OP_T1_N:  ta_r <= prod;
      rplp_pkg::OP_T2_N:  cn_r <= ta_r - prod;
      rplp_pkg::OP_C_N:   ta_r <= prod;
      rplp_pkg::OP_C_D:   cd_r <= prod;
      rplp_pkg::OP_T3_N:  tb_r <= prod;
      rplp_pkg::OP_T4_N:  ta_r <= prod;
      rplp_pkg::OP_CX_N:  cn_r <= ta_r + tb_r;
      rplp_pkg::OP_CX_D:  cd_r <= prod;
      rplp_pkg::OP_KK_N:  dn_r <= prod;
      rplp_pkg::OP_KK_D:  dd_r <= prod;
      rplp_pkg::OP_D_N:   dn_r <= dn_r + dd_r;
      rplp_pkg::OP_KC_N:  en_r <= prod;
      rplp_pkg::OP_KC_D:  ed_r <= prod;
      rplp_pkg::OP_Q1_N:  ta_r <= prod;
      rplp_pkg::OP_Q1_D:  ed_r <= prod;
      rplp_pkg::OP_Q2_N:  tb_r <= prod;
      rplp_pkg::OP_Q2_D:  begin cd_r <= prod; en_r <= ta_r; end
      rplp_pkg::OP_X_A:   ta_r <= prod;
      rplp_pkg::OP_X_B:   xn_r <= ta_r - prod;
      rplp_pkg::OP_X_D:   begin xd_r <= prod; cn_r <= tb_r; end
      rplp_pkg::OP_Y_A:   begin ta_r <= prod; dd_r <= cd_r; end
      rplp_pkg::OP_Y_B:   yn_r <= ta_r + prod;
      rplp_pkg::OP_Y_D:   yd_r <= prod;
      rplp_pkg::OP_VERT: begin
        xn_r <= nn_r;  xd_r <= nd_r;
        yn_r <= pyn_r; yd_r <= pyd_r;
      end
      default: ;
    endcase
    // Reduced fraction writes back after both exact divisions.
    if (gst_r == G_DIVD && dv_done) begin
      if (sel_y_r) begin yn_r <= fn_r; yd_r <= dv_q; end
      else         begin xn_r <= fn_r; xd_r <= dv_q; end
    end
  end

  // Euclid loop and reduction sequencer on the shared divider.
  always_comb begin
    dv_a = g_r;
    dv_b = h_r;
    case (gst_r)
      G_REM: begin
        dv_a = g_r; dv_b = h_r;
      end
      G_DIVN: begin
        dv_a = fn_r; dv_b = g_r;
      end
      G_DIVD: begin
        dv_a = fd_r; dv_b = g_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gst_r  <= G_IDLE;
      zero_r <= 1'b0;
    end else begin
      if (cmd.op == rplp_pkg::OP_LOAD) zero_r <= 1'b0;
      case (gst_r)
        G_IDLE: begin
          if (cmd.gcd_start) begin
            sel_y_r <= cmd.gcd_sel_y;
            g_r  <= cmd.gcd_sel_y ? yn_r : xn_r;
            h_r  <= cmd.gcd_sel_y ? yd_r : xd_r;
            fn_r <= cmd.gcd_sel_y ? yn_r : xn_r;
            fd_r <= cmd.gcd_sel_y ? yd_r : xd_r;
            gst_r <= G_REM;
          end
        end
        G_REM: begin
          if (dv_done) begin
            g_r <= h_r;
            h_r <= dv_r;
            if (dv_r == '0) begin
              if (h_r == '0) begin
                zero_r <= 1'b1;
                gst_r  <= G_IDLE;
              end else begin
                gst_r <= G_DIVN;
              end
            end
          end else if (h_r == '0) begin
            // Nothing to divide: GCD is the numerator itself.
            if (g_r == '0) begin
              zero_r <= 1'b1;
              gst_r  <= G_IDLE;
            end else begin
              gst_r <= G_DIVN;
            end
          end
        end
        G_DIVN: if (dv_done) begin fn_r <= dv_q; gst_r <= G_DIVD; end
        G_DIVD: if (dv_done) gst_r <= G_IDLE;
        default: gst_r <= G_IDLE;
      endcase
    end
  end

  // Launch one division on entry to a step, and again per Euclid iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) go_r <= 1'b0;
    else go_r <= (gst_r == G_IDLE && cmd.gcd_start) ||
                 (gst_r == G_REM && dv_done && dv_r != '0) ||
                 (gst_r == G_REM && !dv_done && h_r == '0 && g_r != '0) ||
                 (gst_r == G_REM && dv_done && dv_r == '0 && h_r != '0) ||
                 (gst_r == G_DIVN && dv_done);
  end

  // A zero denominator on entry skips the remainder loop.
  assign dv_go = go_r && !(gst_r == G_REM && h_r == '0);

  rplp_divider #(.WORD_BITS(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_go),
    .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quotient(dv_q), .remainder(dv_r)
  );

  assign sts.busy = (gst_r != G_IDLE) || go_r;
  assign res_x_num = out_w(xn_r);
  assign res_x_den = out_w(xd_r);
  assign res_y_num = out_w(yn_r);
  assign res_y_den = out_w(yd_r);
  assign res_zero  = zero_r;
endmodule

// ===== design/rplp_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: steps the datapath through the fraction formulas, then the two
// reductions (a vertical line takes only the OP_VERT step), and holds the handshake.
module rplp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_is_vertical,
  output logic              out_valid,
  input  logic              out_stall,
  output rplp_pkg::dp_cmd_t cmd,
  input  rplp_pkg::dp_sts_t sts
);
  typedef enum logic [2:0] {S_IDLE, S_CALC, S_GX, S_WX, S_GY, S_WY, S_OUT} state_t;

  state_t           state_r;
  rplp_pkg::dp_op_t op_r;
  logic             out_valid_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.op        = rplp_pkg::OP_NOP;
    cmd.gcd_start = 1'b0;
    cmd.gcd_sel_y = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) cmd.op = rplp_pkg::OP_LOAD;
      S_CALC: cmd.op = op_r;
      S_GX:   cmd.gcd_start = 1'b1;
      S_GY:   begin cmd.gcd_start = 1'b1; cmd.gcd_sel_y = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= rplp_pkg::OP_NOP;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_CALC;
            op_r    <= in_is_vertical ? rplp_pkg::OP_VERT : rplp_pkg::OP_KPX_N;
          end
        end
        S_CALC: begin
          if (op_r == rplp_pkg::OP_VERT) begin
            state_r     <= S_OUT;
            out_valid_r <= 1'b1;
          end else if (op_r == rplp_pkg::OP_Y_D) begin
            state_r <= S_GX;
          end else begin
            op_r <= rplp_pkg::dp_op_t'(op_r + 1'b1);
          end
        end
        S_GX: state_r <= S_WX;
        S_WX: if (!sts.busy) state_r <= S_GY;
        S_GY: state_r <= S_WY;
        S_WY: begin
          if (!sts.busy) begin
            state_r     <= S_OUT;
            out_valid_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [31:0] in_point_x_num, in_point_x_den, in_point_y_num, in_point_y_den;
  logic [31:0] in_slope_num, in_slope_den, in_offset_num, in_offset_den;
  logic in_is_vertical;
  logic out_valid;
  logic out_stall;
  logic [31:0] out_proj_x_num, out_proj_x_den, out_proj_y_num, out_proj_y_den;
  logic out_zero_gcd;

  typedef struct packed {
    logic signed [31:0] x_num;
    logic signed [31:0] x_den;
    logic signed [31:0] y_num;
    logic signed [31:0] y_den;
    logic zero_gcd;
  } projection_t;

  typedef struct packed {
    logic signed [31:0] num;
    logic signed [31:0] den;
  } ratio_t;

  projection_t expected_q[$];
  int errors;
  int quiet_cycles;
  bit rx_idle_en;
  bit tx_idle_en;
  bit rx_hold;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 3000;

  rational_point_line_projection u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x_num(in_point_x_num), .in_point_x_den(in_point_x_den),
    .in_point_y_num(in_point_y_num), .in_point_y_den(in_point_y_den),
    .in_slope_num(in_slope_num), .in_slope_den(in_slope_den),
    .in_offset_num(in_offset_num), .in_offset_den(in_offset_den),
    .in_is_vertical(in_is_vertical),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_proj_x_num(out_proj_x_num), .out_proj_x_den(out_proj_x_den),
    .out_proj_y_num(out_proj_y_num), .out_proj_y_den(out_proj_y_den),
    .out_zero_gcd(out_zero_gcd)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fraction arithmetic, every product and sum wrapping at 32 bits.
  function automatic ratio_t rat_add(ratio_t a, ratio_t b);
    ratio_t r;
    r.num = a.num * b.den + b.num * a.den;
    r.den = a.den * b.den;
    return r;
  endfunction

  function automatic ratio_t rat_sub(ratio_t a, ratio_t b);
    ratio_t r;
    r.num = a.num * b.den - b.num * a.den;
    r.den = a.den * b.den;
    return r;
  endfunction

  function automatic ratio_t rat_mul(ratio_t a, ratio_t b);
    ratio_t r;
    r.num = a.num * b.num;
    r.den = a.den * b.den;
    return r;
  endfunction

  function automatic ratio_t rat_div(ratio_t a, ratio_t b);
    ratio_t r;
    r.num = a.num * b.den;
    r.den = a.den * b.num;
    return r;
  endfunction

  // Truncating quotient; most negative over minus one wraps to itself.
  function automatic logic signed [31:0] trunc_quot(logic signed [31:0] a,
                                                    logic signed [31:0] b);
    logic [31:0] q;
    logic [31:0] ma;
    logic [31:0] mb;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic logic signed [31:0] trunc_rem(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    logic [31:0] r;
    logic [31:0] ma;
    logic [31:0] mb;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    r = ma % mb;
    return a[31] ? -r : r;
  endfunction

  // Reduce by the unnormalized Euclid GCD; returns 1 when the GCD is zero.
  function automatic bit reduce_ratio(inout ratio_t f);
    logic signed [31:0] g;
    logic signed [31:0] h;
    logic signed [31:0] r;
    g = f.num;
    h = f.den;
    while (h != 0) begin
      r = trunc_rem(g, h);
      g = h;
      h = r;
    end
    if (g == 0) return 1'b1;
    f.num = trunc_quot(f.num, g);
    f.den = trunc_quot(f.den, g);
    return 1'b0;
  endfunction

  function automatic projection_t project_point(logic [31:0] v[8], bit vert);
    projection_t p;
    ratio_t px, py, k, n, x, y, c, d, one;
    bit zx, zy;
    px = {v[0], v[1]};
    py = {v[2], v[3]};
    k = {v[4], v[5]};
    n = {v[6], v[7]};
    one = {32'sd1, 32'sd1};
    zx = 1'b0;
    zy = 1'b0;
    if (vert) begin
      x = n;
      y = py;
    end else begin
      c = rat_add(rat_sub(rat_mul(k, px), py), n);
      d = rat_add(rat_mul(k, k), one);
      x = rat_sub(px, rat_div(rat_mul(k, c), d));
      y = rat_add(py, rat_div(c, d));
      zx = reduce_ratio(x);
      zy = reduce_ratio(y);
    end
    p.x_num = x.num;
    p.x_den = x.den;
    p.y_num = y.num;
    p.y_den = y.den;
    p.zero_gcd = zx | zy;
    return p;
  endfunction

  // Offer one request and hold it until accepted; queue its expected result.
  // Valid stays high after acceptance until the next request or an idle cycle.
  task automatic send_request(logic [31:0] v[8], bit vert);
    while (tx_idle_en && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x_num <= v[0];
    in_point_x_den <= v[1];
    in_point_y_num <= v[2];
    in_point_y_den <= v[3];
    in_slope_num <= v[4];
    in_slope_den <= v[5];
    in_offset_num <= v[6];
    in_offset_den <= v[7];
    in_is_vertical <= vert;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(project_point(v, vert));
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4, 5: return $urandom_range(40) - 20;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] v[8];
    logic [31:0] corner[6];
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0, 32'd1, 32'd2};
    // Simple horizontal line and identity-like slope.
    v = '{3, 1, 4, 1, 0, 1, 2, 1};
    send_request(v, 1'b0);
    v = '{1, 2, 3, 4, 1, 1, 0, 1};
    send_request(v, 1'b0);
    // Vertical lines, including extreme values.
    v = '{5, 7, -9, 4, 3, 2, 11, 13};
    send_request(v, 1'b1);
    v = '{0, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 32'h8000_0000};
    send_request(v, 1'b1);
    // All zeros gives a zero GCD; zero denominators flow through.
    v = '{0, 0, 0, 0, 0, 0, 0, 0};
    send_request(v, 1'b0);
    v = '{1, 0, 1, 0, 1, 0, 1, 0};
    send_request(v, 1'b0);
    // Most negative over minus one inside the reduction.
    v = '{32'h8000_0000, 32'hffff_ffff, 0, 1, 0, 1, 0, 1};
    send_request(v, 1'b0);
    v = '{-7, 3, 5, -2, -1, 3, -4, -5};
    send_request(v, 1'b0);
    for (int i = 0; i < 12; i++) begin
      for (int j = 0; j < 8; j++) v[j] = corner[(i + j) % 6];
      send_request(v, i[0]);
    end
    for (int j = 0; j < 8; j++) v[j] = 32'hffff_ffff;
    send_request(v, 1'b0);
    for (int j = 0; j < 8; j++) v[j] = 32'h7fff_ffff;
    send_request(v, 1'b0);
  endtask

  task automatic test_random(int count);
    logic [31:0] v[8];
    for (int i = 0; i < count; i++) begin
      for (int j = 0; j < 8; j++) v[j] = rand_word();
      send_request(v, $urandom_range(9) == 0);
    end
  endtask

  // Receiver holds off for a long time while requests keep coming.
  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (4000) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        test_random(10);
        in_valid <= 1'b0;
      end
    join
  endtask

  // Receiver stall generator.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= rx_hold || (rx_idle_en && $urandom_range(99) < 30);
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    projection_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d/%0d y=%0d/%0d", $time,
                 $signed(out_proj_x_num), $signed(out_proj_x_den),
                 $signed(out_proj_y_num), $signed(out_proj_y_den));
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_proj_x_num !== want.x_num) begin
          $display("%0t: x_num expected %0d actual %0d", $time, want.x_num,
                   $signed(out_proj_x_num));
          errors++;
        end
        if (out_proj_x_den !== want.x_den) begin
          $display("%0t: x_den expected %0d actual %0d", $time, want.x_den,
                   $signed(out_proj_x_den));
          errors++;
        end
        if (out_proj_y_num !== want.y_num) begin
          $display("%0t: y_num expected %0d actual %0d", $time, want.y_num,
                   $signed(out_proj_y_num));
          errors++;
        end
        if (out_proj_y_den !== want.y_den) begin
          $display("%0t: y_den expected %0d actual %0d", $time, want.y_den,
                   $signed(out_proj_y_den));
          errors++;
        end
        if (out_zero_gcd !== want.zero_gcd) begin
          $display("%0t: zero_gcd expected %0b actual %0b", $time, want.zero_gcd,
                   out_zero_gcd);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rx_hold) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    quiet_cycles = 0;
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    rx_hold = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_point_x_num = '0;
    in_point_x_den = '0;
    in_point_y_num = '0;
    in_point_y_den = '0;
    in_slope_num = '0;
    in_slope_den = '0;
    in_offset_num = '0;
    in_offset_den = '0;
    in_is_vertical = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300);
    wait_drained();
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
    test_random(500);
    test_backpressure();
    wait_drained();
    test_random(500);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
